>>> src/obb_pkg.sv
// ----------------------------------------------------------------------------
// obb_pkg
// Shared types, codes and index tables for the OBB separating axis test.
// ----------------------------------------------------------------------------
package obb_pkg;

   localparam int DIGIT = 32;
   localparam int STORE_DEPTH = 30;
   localparam int ADDR_W = 5;

   localparam logic CMD_LOAD = 1'b0;
   localparam logic CMD_TEST = 1'b1;

   localparam logic [2:0] SLOT_CENTER = 3'd0;
   localparam logic [2:0] SLOT_AXIS_X = 3'd1;
   localparam logic [2:0] SLOT_HALF   = 3'd4;
   localparam logic [2:0] SLOT_MAX    = 3'd4;

   localparam logic [3:0] FACE_AXES = 4'd6;
   localparam logic [3:0] LAST_AXIS = 4'd14;
   localparam logic [2:0] TERM_CENTER = 3'd0;
   localparam logic [2:0] LAST_TERM = 3'd6;
   localparam logic [1:0] LAST_COMP = 2'd2;

   typedef struct packed {
      logic       is_test;
      logic       box;
      logic [2:0] slot;
   } ctl_type;

   function automatic logic [ADDR_W-1:0] store_addr(input logic box, input logic [2:0] slot,
                                                    input logic [1:0] comp);
      logic [ADDR_W-1:0] a;
      a = box ? 5'd15 : 5'd0;
      a = a + 5'(slot) * 5'd3 + 5'(comp);
      return a;
   endfunction

   // next and second next component of a cross product
   function automatic logic [1:0] nxt1(input logic [1:0] i);
      logic [1:0] r;
      case (i)
         2'd0: r = 2'd1;
         2'd1: r = 2'd2;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic logic [1:0] nxt2(input logic [1:0] i);
      logic [1:0] r;
      case (i)
         2'd0: r = 2'd2;
         2'd1: r = 2'd0;
         default: r = 2'd1;
      endcase
      return r;
   endfunction

   function automatic logic face_box(input logic [3:0] n);
      return (n >= 4'd3);
   endfunction

   function automatic logic [1:0] face_k(input logic [3:0] n);
      logic [1:0] r;
      case (n)
         4'd0, 4'd3: r = 2'd0;
         4'd1, 4'd4: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

   // box 0 axis used by a cross axis
   function automatic logic [1:0] cross_u(input logic [3:0] n);
      logic [1:0] r;
      case (n)
         4'd6, 4'd7, 4'd8:    r = 2'd0;
         4'd9, 4'd10, 4'd11:  r = 2'd1;
         default:             r = 2'd2;
      endcase
      return r;
   endfunction

   // box 1 axis used by a cross axis
   function automatic logic [1:0] cross_v(input logic [3:0] n);
      logic [1:0] r;
      case (n)
         4'd6, 4'd9, 4'd12:   r = 2'd0;
         4'd7, 4'd10, 4'd13:  r = 2'd1;
         default:             r = 2'd2;
      endcase
      return r;
   endfunction

   function automatic logic term_box(input logic [2:0] t);
      return (t >= 3'd4);
   endfunction

   function automatic logic [1:0] term_k(input logic [2:0] t);
      logic [1:0] r;
      case (t)
         3'd1, 3'd4: r = 2'd0;
         3'd2, 3'd5: r = 2'd1;
         default:    r = 2'd2;
      endcase
      return r;
   endfunction

endpackage

>>> src/obb_front.sv
// ----------------------------------------------------------------------------
// obb_front
// Accepts request items, drops loads to unused slots, queues the rest.
// ----------------------------------------------------------------------------
module obb_front #(
   parameter int COMP_WIDTH = 32
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_command,
   input  logic                         req_box_id,
   input  logic [2:0]                   req_slot,
   input  logic signed [COMP_WIDTH-1:0] req_comp_x,
   input  logic signed [COMP_WIDTH-1:0] req_comp_y,
   input  logic signed [COMP_WIDTH-1:0] req_comp_z,
   output logic                         q_valid,
   input  logic                         q_pop,
   output obb_pkg::ctl_type             q_ctl,
   output logic [3*COMP_WIDTH-1:0]      q_data
);

   obb_pkg::ctl_type            ctl_ff [2];
   logic [3*COMP_WIDTH-1:0]     data_ff [2];
   logic                        wr_ptr_ff, wr_ptr_in;
   logic                        rd_ptr_ff, rd_ptr_in;
   logic [1:0]                  count_ff, count_in;
   logic                        enq;

   assign full    = (count_ff == 2'd2);
   assign q_valid = (count_ff != 2'd0);
   assign q_ctl   = ctl_ff[rd_ptr_ff];
   assign q_data  = data_ff[rd_ptr_ff];

   assign enq = push && !full &&
                ((req_command == obb_pkg::CMD_TEST) || (req_slot <= obb_pkg::SLOT_MAX));

   always_comb begin
      wr_ptr_in = enq ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = q_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(enq) - 2'(q_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enq) begin
         ctl_ff[wr_ptr_ff]  <= '{is_test: req_command, box: req_box_id, slot: req_slot};
         data_ff[wr_ptr_ff] <= {req_comp_z, req_comp_y, req_comp_x};
      end
   end

endmodule

>>> src/obb_mac.sv
// ----------------------------------------------------------------------------
// obb_mac
// Digit-serial signed multiply-accumulate: narrow x times wide y.
// ----------------------------------------------------------------------------
module obb_mac #(
   parameter int XW  = 33,
   parameter int YW  = 152,
   parameter int NDW = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic                 clr,
   input  logic                 neg,
   input  logic signed [XW-1:0] x,
   input  logic signed [YW-1:0] y,
   input  logic [NDW-1:0]       nd,
   output logic signed [YW-1:0] acc,
   output logic                 done
);

   localparam int PW = XW + obb_pkg::DIGIT + 1;

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic signed [XW-1:0] xr_ff, xr_in;
   logic signed [YW-1:0] yr_ff, yr_in;
   logic [NDW-1:0]       j_ff, j_in;
   logic [NDW-1:0]       last_ff, last_in;
   logic signed [YW-1:0] acc_ff, acc_in;
   logic                 last;
   logic signed [obb_pkg::DIGIT:0] digit;
   logic signed [PW-1:0] pp;
   logic signed [YW-1:0] ppx;

   assign last  = (j_ff == last_ff);
   assign digit = {last & yr_ff[obb_pkg::DIGIT-1], yr_ff[obb_pkg::DIGIT-1:0]};
   assign pp    = xr_ff * digit;
   assign ppx   = YW'(pp);
   assign acc   = acc_ff;
   assign done  = done_ff;

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      xr_in   = xr_ff;
      yr_in   = yr_ff;
      j_in    = j_ff;
      last_in = last_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         xr_in   = neg ? -x : x;
         yr_in   = y;
         j_in    = '0;
         last_in = nd - NDW'(1);
         if (clr) begin
            acc_in = '0;
         end
      end else if (busy_ff) begin
         acc_in = acc_ff + (ppx <<< (j_ff * obb_pkg::DIGIT));
         yr_in  = yr_ff >>> obb_pkg::DIGIT;
         j_in   = j_ff + NDW'(1);
         if (last) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      xr_ff   <= xr_in;
      yr_ff   <= yr_in;
      j_ff    <= j_in;
      last_ff <= last_in;
      acc_ff  <= acc_in;
   end

endmodule

>>> src/obb_back.sv
// ----------------------------------------------------------------------------
// obb_back
// Vector store, axis sequencer and result register.
// ----------------------------------------------------------------------------
module obb_back #(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    q_valid,
   output logic                    q_pop,
   input  obb_pkg::ctl_type        q_ctl,
   input  logic [3*COMP_WIDTH-1:0] q_data,
   output logic                    empty,
   input  logic                    pop,
   output logic                    rsp_intersects
);

   localparam int C    = COMP_WIDTH;
   localparam int W    = 4 * C + FRAC_BITS + 8;
   localparam int XW   = C + 1;
   localparam int LW   = 2 * C + 2;
   localparam int ND_A = (C + obb_pkg::DIGIT - 1) / obb_pkg::DIGIT;
   localparam int ND_L = (2 * C + 1 + obb_pkg::DIGIT - 1) / obb_pkg::DIGIT;
   localparam int ND_P = (3 * C + 3 + obb_pkg::DIGIT - 1) / obb_pkg::DIGIT;
   localparam int NDW  = $clog2(ND_P + 1);

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_DIFF0 = 4'd1;
   localparam logic [3:0] S_DIFF1 = 4'd2;
   localparam logic [3:0] S_AXIS  = 4'd3;
   localparam logic [3:0] S_LFACE = 4'd4;
   localparam logic [3:0] S_CFET  = 4'd5;
   localparam logic [3:0] S_CMAC  = 4'd6;
   localparam logic [3:0] S_CWAIT = 4'd7;
   localparam logic [3:0] S_DOT   = 4'd8;
   localparam logic [3:0] S_DWAIT = 4'd9;
   localparam logic [3:0] S_SCALE = 4'd10;
   localparam logic [3:0] S_SWAIT = 4'd11;
   localparam logic [3:0] S_CMP   = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [C-1:0]         store_ff [obb_pkg::STORE_DEPTH];
   logic [3:0]           state_ff, state_in;
   logic [3:0]           n_ff, n_in;
   logic [2:0]           t_ff, t_in;
   logic [1:0]           i_ff, i_in;
   logic                 hf_ff, hf_in;
   logic [C-1:0]         tmp_ff, tmp_in;
   logic signed [XW-1:0] d_ff [3];
   logic signed [XW-1:0] d_in;
   logic signed [LW-1:0] l_ff [3];
   logic signed [LW-1:0] l_in;
   logic                 d_we, l_we;
   logic signed [W-1:0]  p_ff, p_in;
   logic [W-1:0]         lhs_ff, lhs_in;
   logic [W-1:0]         rhs_ff, rhs_in;
   logic                 res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_int_ff, rsp_int_in;
   logic                 load_we;

   logic [obb_pkg::ADDR_W-1:0] rd_addr;
   logic signed [C-1:0]  rd_data;
   logic [W-1:0]         acc_abs;

   logic                 mac_start, mac_clr, mac_neg, mac_done;
   logic signed [XW-1:0] mac_x;
   logic signed [W-1:0]  mac_y, mac_acc;
   logic [NDW-1:0]       mac_nd;

   obb_mac #(.XW(XW), .YW(W), .NDW(NDW)) u_mac (
      .clock (clock),
      .reset (reset),
      .start (mac_start),
      .clr   (mac_clr),
      .neg   (mac_neg),
      .x     (mac_x),
      .y     (mac_y),
      .nd    (mac_nd),
      .acc   (mac_acc),
      .done  (mac_done)
   );

   assign empty          = !rsp_valid_ff;
   assign rsp_intersects = rsp_int_ff;
   assign rd_data        = store_ff[rd_addr];
   assign acc_abs        = mac_acc[W-1] ? W'(-mac_acc) : W'(mac_acc);

   always_comb begin
      case (state_ff)
         S_DIFF0: rd_addr = obb_pkg::store_addr(1'b0, obb_pkg::SLOT_CENTER, i_ff);
         S_DIFF1: rd_addr = obb_pkg::store_addr(1'b1, obb_pkg::SLOT_CENTER, i_ff);
         S_LFACE: rd_addr = obb_pkg::store_addr(obb_pkg::face_box(n_ff),
                               obb_pkg::SLOT_AXIS_X + 3'(obb_pkg::face_k(n_ff)), i_ff);
         S_CFET:  rd_addr = obb_pkg::store_addr(1'b1,
                               obb_pkg::SLOT_AXIS_X + 3'(obb_pkg::cross_v(n_ff)),
                               hf_ff ? obb_pkg::nxt1(i_ff) : obb_pkg::nxt2(i_ff));
         S_CMAC:  rd_addr = obb_pkg::store_addr(1'b0,
                               obb_pkg::SLOT_AXIS_X + 3'(obb_pkg::cross_u(n_ff)),
                               hf_ff ? obb_pkg::nxt2(i_ff) : obb_pkg::nxt1(i_ff));
         S_DOT:   rd_addr = obb_pkg::store_addr(obb_pkg::term_box(t_ff),
                               obb_pkg::SLOT_AXIS_X + 3'(obb_pkg::term_k(t_ff)), i_ff);
         S_SCALE: rd_addr = obb_pkg::store_addr(obb_pkg::term_box(t_ff),
                               obb_pkg::SLOT_HALF, obb_pkg::term_k(t_ff));
         default: rd_addr = '0;
      endcase
   end

   always_comb begin
      state_in     = state_ff;
      n_in         = n_ff;
      t_in         = t_ff;
      i_in         = i_ff;
      hf_in        = hf_ff;
      tmp_in       = tmp_ff;
      d_in         = XW'(rd_data) - XW'(signed'(tmp_ff));
      d_we         = 1'b0;
      l_in         = LW'(rd_data);
      l_we         = 1'b0;
      p_in         = p_ff;
      lhs_in       = lhs_ff;
      rhs_in       = rhs_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff && !pop;
      rsp_int_in   = rsp_int_ff;
      load_we      = 1'b0;
      q_pop        = 1'b0;
      mac_start    = 1'b0;
      mac_clr      = 1'b0;
      mac_neg      = 1'b0;
      mac_x        = XW'(rd_data);
      mac_y        = W'(l_ff[i_ff]);
      mac_nd       = NDW'(ND_L);
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               if (q_ctl.is_test == obb_pkg::CMD_TEST) begin
                  i_in     = '0;
                  n_in     = '0;
                  state_in = S_DIFF0;
               end else begin
                  load_we = 1'b1;
               end
            end
         end
         S_DIFF0: begin
            tmp_in   = rd_data;
            state_in = S_DIFF1;
         end
         S_DIFF1: begin
            d_we = 1'b1;
            if (i_ff == obb_pkg::LAST_COMP) begin
               state_in = S_AXIS;
            end else begin
               i_in     = i_ff + 2'd1;
               state_in = S_DIFF0;
            end
         end
         S_AXIS: begin
            rhs_in   = '0;
            i_in     = '0;
            hf_in    = 1'b0;
            state_in = (n_ff < obb_pkg::FACE_AXES) ? S_LFACE : S_CFET;
         end
         S_LFACE: begin
            l_we = 1'b1;
            if (i_ff == obb_pkg::LAST_COMP) begin
               i_in     = '0;
               t_in     = obb_pkg::TERM_CENTER;
               state_in = S_DOT;
            end else begin
               i_in = i_ff + 2'd1;
            end
         end
         S_CFET: begin
            tmp_in   = rd_data;
            state_in = S_CMAC;
         end
         S_CMAC: begin
            mac_start = 1'b1;
            mac_clr   = !hf_ff;
            mac_neg   = hf_ff;
            mac_y     = W'(signed'(tmp_ff));
            mac_nd    = NDW'(ND_A);
            state_in  = S_CWAIT;
         end
         S_CWAIT: begin
            if (mac_done) begin
               if (hf_ff) begin
                  l_in  = LW'(mac_acc);
                  l_we  = 1'b1;
                  hf_in = 1'b0;
                  if (i_ff == obb_pkg::LAST_COMP) begin
                     i_in     = '0;
                     t_in     = obb_pkg::TERM_CENTER;
                     state_in = S_DOT;
                  end else begin
                     i_in     = i_ff + 2'd1;
                     state_in = S_CFET;
                  end
               end else begin
                  hf_in    = 1'b1;
                  state_in = S_CFET;
               end
            end
         end
         S_DOT: begin
            mac_start = 1'b1;
            mac_clr   = (i_ff == 2'd0);
            if (t_ff == obb_pkg::TERM_CENTER) begin
               mac_x = d_ff[i_ff];
            end
            state_in = S_DWAIT;
         end
         S_DWAIT: begin
            if (mac_done) begin
               if (i_ff != obb_pkg::LAST_COMP) begin
                  i_in     = i_ff + 2'd1;
                  state_in = S_DOT;
               end else begin
                  i_in = '0;
                  if (t_ff == obb_pkg::TERM_CENTER) begin
                     lhs_in   = acc_abs << FRAC_BITS;
                     t_in     = t_ff + 3'd1;
                     state_in = S_DOT;
                  end else begin
                     p_in     = mac_acc;
                     state_in = S_SCALE;
                  end
               end
            end
         end
         S_SCALE: begin
            mac_start = 1'b1;
            mac_clr   = 1'b1;
            mac_y     = p_ff;
            mac_nd    = NDW'(ND_P);
            state_in  = S_SWAIT;
         end
         S_SWAIT: begin
            if (mac_done) begin
               rhs_in = rhs_ff + acc_abs;
               if (t_ff == obb_pkg::LAST_TERM) begin
                  state_in = S_CMP;
               end else begin
                  t_in     = t_ff + 3'd1;
                  state_in = S_DOT;
               end
            end
         end
         S_CMP: begin
            if (lhs_ff > rhs_ff) begin
               res_in   = 1'b0;
               state_in = S_DONE;
            end else if (n_ff == obb_pkg::LAST_AXIS) begin
               res_in   = 1'b1;
               state_in = S_DONE;
            end else begin
               n_in     = n_ff + 4'd1;
               state_in = S_AXIS;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || pop) begin
               rsp_valid_in = 1'b1;
               rsp_int_in   = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int e = 0; e < obb_pkg::STORE_DEPTH; e++) begin
            store_ff[e] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (load_we) begin
            for (int c = 0; c < 3; c++) begin
               store_ff[obb_pkg::store_addr(q_ctl.box, q_ctl.slot, 2'(c))] <=
                  q_data[c*C +: C];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      n_ff       <= n_in;
      t_ff       <= t_in;
      i_ff       <= i_in;
      hf_ff      <= hf_in;
      tmp_ff     <= tmp_in;
      p_ff       <= p_in;
      lhs_ff     <= lhs_in;
      rhs_ff     <= rhs_in;
      res_ff     <= res_in;
      rsp_int_ff <= rsp_int_in;
      if (d_we) begin
         d_ff[i_ff] <= d_in;
      end
      if (l_we) begin
         l_ff[i_ff] <= l_in;
      end
   end

endmodule

>>> src/obb_separating_axis_test.sv
// ----------------------------------------------------------------------------
// obb_separating_axis_test
// Oriented bounding box overlap test over fifteen separating axes.
// ----------------------------------------------------------------------------
// Request side is a queue: drive req_* and push while full is low. A load
// (req_command 0) writes center, an axis or the half sizes of one box; loads
// to slots above the half sizes are dropped. A test (req_command 1) yields
// one rsp_intersects result on the response queue: read it while empty is
// low and pop to take it.
// A two-entry queue separates intake from the sequencer. Loads retire one
// per cycle while the sequencer is idle. A test runs the axes one after
// another through a single digit-serial multiply-accumulate unit
// (COMP_WIDTH+1 by 33 bits per cycle); the first separating axis ends the
// test early. The sequencer takes the next queued item as soon as the result
// is parked in the output register; if that register is still unread when
// the following test finishes, the sequencer waits on it.
// Reset clears the vector store to zero and empties both queues.
// ----------------------------------------------------------------------------
module obb_separating_axis_test #(
   parameter int COMP_WIDTH = 32,
   parameter int FRAC_BITS  = 16
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic                         req_command,
   input  logic                         req_box_id,
   input  logic [2:0]                   req_slot,
   input  logic signed [COMP_WIDTH-1:0] req_comp_x,
   input  logic signed [COMP_WIDTH-1:0] req_comp_y,
   input  logic signed [COMP_WIDTH-1:0] req_comp_z,
   output logic                         empty,
   input  logic                         pop,
   output logic                         rsp_intersects
);

   logic                    q_valid;
   logic                    q_pop;
   obb_pkg::ctl_type        q_ctl;
   logic [3*COMP_WIDTH-1:0] q_data;

   obb_front #(.COMP_WIDTH(COMP_WIDTH)) u_front (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_command (req_command),
      .req_box_id  (req_box_id),
      .req_slot    (req_slot),
      .req_comp_x  (req_comp_x),
      .req_comp_y  (req_comp_y),
      .req_comp_z  (req_comp_z),
      .q_valid     (q_valid),
      .q_pop       (q_pop),
      .q_ctl       (q_ctl),
      .q_data      (q_data)
   );

   obb_back #(.COMP_WIDTH(COMP_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_pop          (q_pop),
      .q_ctl          (q_ctl),
      .q_data         (q_data),
      .empty          (empty),
      .pop            (pop),
      .rsp_intersects (rsp_intersects)
   );

`ifndef SYNTHESIS
   a_qpop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("queue popped while empty");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty)
      else $error("result lost before transfer");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> empty)
      else $error("result pending after reset");
`endif

endmodule

>>> verif/obb_separating_axis_test_tb.sv
// ----------------------------------------------------------------------------
// obb_separating_axis_test_tb
// Self-checking bench for the fifteen-axis OBB overlap test: loads and tests
// are pushed with random gaps, an exact wide-integer predictor tracks the
// vector store and each popped intersect bit is checked in order.
// ----------------------------------------------------------------------------
module obb_separating_axis_test_tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [255:0] wide_t;
   typedef logic signed [31:0] comp_t;

   localparam comp_t ONE  = 32'sh0001_0000;
   localparam comp_t CMAX = 32'sh7fff_ffff;
   localparam comp_t CMIN = 32'sh8000_0000;

   class overlap_scoreboard;
      comp_t store [obb_pkg::STORE_DEPTH];
      bit    verdicts [$];
      int    mismatches;

      function new();
         foreach (store[i]) store[i] = '0;
         mismatches = 0;
      endfunction

      function wide_t entry(int box, int slot, int comp);
         wide_t w;
         w = store[box * 15 + slot * 3 + comp];
         return w;
      endfunction

      function wide_t wabs(wide_t v);
         return (v < 0) ? -v : v;
      endfunction

      function bit boxes_overlap();
         wide_t d [3];
         wide_t ax [2][3][3];
         wide_t ext [2][3][3];
         wide_t pl [15][3];
         wide_t lhs, rhs, h;
         int n;
         for (int i = 0; i < 3; i++)
            d[i] = (entry(1, 0, i) - entry(0, 0, i)) <<< 16;
         for (int b = 0; b < 2; b++)
            for (int k = 0; k < 3; k++) begin
               h = entry(b, 4, k);
               for (int i = 0; i < 3; i++) begin
                  ax[b][k][i] = entry(b, 1 + k, i);
                  ext[b][k][i] = ax[b][k][i] * h;
               end
            end
         n = 0;
         for (int b = 0; b < 2; b++)
            for (int k = 0; k < 3; k++) begin
               for (int i = 0; i < 3; i++) pl[n][i] = ax[b][k][i];
               n++;
            end
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) begin
               pl[n][0] = ax[0][i][1] * ax[1][j][2] - ax[0][i][2] * ax[1][j][1];
               pl[n][1] = ax[0][i][2] * ax[1][j][0] - ax[0][i][0] * ax[1][j][2];
               pl[n][2] = ax[0][i][0] * ax[1][j][1] - ax[0][i][1] * ax[1][j][0];
               n++;
            end
         for (n = 0; n < 15; n++) begin
            lhs = wabs(d[0] * pl[n][0] + d[1] * pl[n][1] + d[2] * pl[n][2]);
            rhs = '0;
            for (int b = 0; b < 2; b++)
               for (int k = 0; k < 3; k++)
                  rhs = rhs + wabs(ext[b][k][0] * pl[n][0] + ext[b][k][1] * pl[n][1]
                                   + ext[b][k][2] * pl[n][2]);
            if (lhs > rhs) return 1'b0;
         end
         return 1'b1;
      endfunction

      function void note_item(logic cmd, logic box, logic [2:0] slot,
                              comp_t x, comp_t y, comp_t z);
         int base;
         if (cmd == obb_pkg::CMD_TEST) begin
            verdicts.push_back(boxes_overlap());
         end else if (slot <= obb_pkg::SLOT_MAX) begin
            base = box * 15 + slot * 3;
            store[base] = x;
            store[base + 1] = y;
            store[base + 2] = z;
         end
      endfunction

      function void check_verdict(logic got);
         bit want;
         if (verdicts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result transfer: intersects=%b", got);
            return;
         end
         want = verdicts.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("intersects mismatch: expected %b actual %b", want, got);
         end
      endfunction
   endclass

   logic  clock = 1'b0;
   logic  reset = 1'b1;
   logic  push = 1'b0;
   logic  pop = 1'b0;
   logic  full, empty, rsp_intersects;
   logic  req_command = obb_pkg::CMD_LOAD;
   logic  req_box_id = 1'b0;
   logic [2:0] req_slot = obb_pkg::SLOT_CENTER;
   comp_t req_comp_x = '0, req_comp_y = '0, req_comp_z = '0;

   overlap_scoreboard sb = new();
   int send_idle = 0;
   int recv_stall = 0;
   bit running = 1'b0;

   obb_separating_axis_test uut (
      .clock(clock), .reset(reset), .push(push), .full(full),
      .req_command(req_command), .req_box_id(req_box_id), .req_slot(req_slot),
      .req_comp_x(req_comp_x), .req_comp_y(req_comp_y), .req_comp_z(req_comp_z),
      .empty(empty), .pop(pop), .rsp_intersects(rsp_intersects)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   task automatic send_item(logic cmd, logic box, logic [2:0] slot,
                            comp_t x, comp_t y, comp_t z);
      bit taken;
      while ($urandom_range(99) < send_idle) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_command <= cmd;
      req_box_id <= box;
      req_slot <= slot;
      req_comp_x <= x;
      req_comp_y <= y;
      req_comp_z <= z;
      do begin
         @(negedge clock);
         taken = !full;
         @(posedge clock);
      end while (!taken);
      sb.note_item(cmd, box, slot, x, y, z);
   endtask

   task automatic load_vec(logic box, logic [2:0] slot, comp_t x, comp_t y, comp_t z);
      send_item(obb_pkg::CMD_LOAD, box, slot, x, y, z);
   endtask

   task automatic run_test();
      send_item(obb_pkg::CMD_TEST, 1'($urandom_range(1)), 3'($urandom_range(7)),
                $urandom, $urandom, $urandom);
   endtask

   function automatic comp_t rand_comp(int mode);
      case (mode)
         0: return $urandom;
         1: return comp_t'($urandom_range(262144)) - 32'sd131072;
         2: begin
            case ($urandom_range(4))
               0: return CMAX;
               1: return CMIN;
               2: return '0;
               3: return -ONE;
               default: return ONE;
            endcase
         end
         default: return comp_t'($urandom_range(2 * 65536)) - ONE;
      endcase
   endfunction

   // result side
   always @(posedge clock) begin
      if (running) pop <= ($urandom_range(99) >= recv_stall);
   end

   always @(negedge clock) begin
      if (running && pop && !empty) sb.check_verdict(rsp_intersects);
   end

   initial begin
      int mode;
      int phase;
      logic [2:0] slot;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      running = 1'b1;

      // directed part
      run_test();
      for (int b = 0; b < 2; b++) begin
         load_vec(1'(b), obb_pkg::SLOT_AXIS_X, ONE, 0, 0);
         load_vec(1'(b), 3'(obb_pkg::SLOT_AXIS_X + 3'd1), 0, ONE, 0);
         load_vec(1'(b), 3'(obb_pkg::SLOT_AXIS_X + 3'd2), 0, 0, ONE);
         load_vec(1'(b), obb_pkg::SLOT_HALF, ONE, ONE, ONE);
      end
      load_vec(1'b1, obb_pkg::SLOT_CENTER, 3 * ONE, 0, 0);
      run_test();
      load_vec(1'b1, obb_pkg::SLOT_CENTER, ONE + ONE / 2, 0, 0);
      run_test();
      load_vec(1'b0, obb_pkg::SLOT_HALF, -ONE, -ONE, -ONE);
      load_vec(1'b1, obb_pkg::SLOT_CENTER, 2 * ONE, 0, 0);
      run_test();
      load_vec(1'b0, obb_pkg::SLOT_CENTER, CMAX, CMAX, CMAX);
      load_vec(1'b1, obb_pkg::SLOT_CENTER, CMIN, CMIN, CMIN);
      run_test();
      load_vec(1'b0, 3'(obb_pkg::SLOT_MAX + 3'd1), CMAX, 0, 0);
      load_vec(1'b1, 3'(obb_pkg::SLOT_MAX + 3'd2), CMIN, CMIN, CMIN);
      load_vec(1'b0, 3'(obb_pkg::SLOT_MAX + 3'd3), -1, -1, -1);
      load_vec(1'b1, obb_pkg::SLOT_AXIS_X, CMIN, CMAX, CMIN);
      load_vec(1'b1, obb_pkg::SLOT_HALF, CMAX, CMIN, CMAX);
      run_test();
      load_vec(1'b0, obb_pkg::SLOT_AXIS_X, 0, 0, 0);
      run_test();

      // random part: box pairs rebuilt in part, then tested
      for (int n = 0; n < 1200; n++) begin
         phase = (n / 150) % 4;
         send_idle = (phase == 1) ? 61 : (phase == 3) ? 30 : 0;
         recv_stall = (phase == 2) ? 61 : (phase == 3) ? 30 : 0;
         if ($urandom_range(9) == 0) begin
            run_test();
         end else begin
            slot = ($urandom_range(19) == 0) ? 3'($urandom_range(7, 5)) : 3'($urandom_range(4));
            case ($urandom_range(9))
               0: mode = 0;
               1: mode = 2;
               2, 3, 4: mode = 1;
               default: mode = 3;
            endcase
            load_vec(1'($urandom_range(1)), slot, rand_comp(mode), rand_comp(mode),
                     rand_comp(mode));
         end
      end
      push <= 1'b0;
      recv_stall = 0;
      while (sb.verdicts.size() != 0) @(posedge clock);
      repeat (3000) @(posedge clock);
      if (sb.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   initial begin
      #40_000_000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
src/obb_pkg.sv
src/obb_front.sv
src/obb_mac.sv
src/obb_back.sv
src/obb_separating_axis_test.sv
verif/obb_separating_axis_test_tb.sv
